FILE: hw/rtl/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg - shared types and constants for the IR pulse-distance transmitter
// Item structs, configuration register map, segment phases and reset timings.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int unsigned TimeW      = 14;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CodeBitsDef = 32;

  localparam logic [TimeW-1:0] LeaderHighRst = TimeW'(9000);
  localparam logic [TimeW-1:0] LeaderLowRst  = TimeW'(4500);
  localparam logic [TimeW-1:0] MarkRst       = TimeW'(550);
  localparam logic [TimeW-1:0] OneSpaceRst   = TimeW'(1700);
  localparam logic [TimeW-1:0] ZeroSpaceRst  = TimeW'(550);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEADER_HIGH = 3'd0,
    CFG_LEADER_LOW  = 3'd1,
    CFG_MARK        = 3'd2,
    CFG_ONE_SPACE   = 3'd3,
    CFG_ZERO_SPACE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEAD_HI = 3'd1,
    PH_LEAD_LO = 3'd2,
    PH_MARK    = 3'd3,
    PH_SPACE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic             mode;
    logic [CodeW-1:0] code_word;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic load_rejected;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] leader_high_time;
    logic [TimeW-1:0] leader_low_time;
    logic [TimeW-1:0] mark_time;
    logic [TimeW-1:0] one_space_time;
    logic [TimeW-1:0] zero_space_time;
  } cfg_t;

  // a zero length segment still lasts one tick
  function automatic logic [TimeW-1:0] seg_len(input logic [TimeW-1:0] t);
    seg_len = (t == '0) ? TimeW'(1) : t;
  endfunction

endpackage

FILE: hw/rtl/irpdt_seq.sv
// ----------------------------------------------------------------------------
// irpdt_seq - frame sequencer
// Segment phase machine, segment timer and code shift register. Computes the
// result of one item from the current state; state advances on step_i.
// ----------------------------------------------------------------------------
module irpdt_seq #(
  parameter int unsigned CODE_BITS = irpdt_pkg::CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  irpdt_pkg::in_item_t  item_i,
  input  irpdt_pkg::cfg_t      cfg_i,
  output irpdt_pkg::out_item_t res_o
);
  import irpdt_pkg::*;

  localparam int unsigned BitsW = $clog2(CODE_BITS + 1);

  phase_e               phase_q, phase_d;
  logic [TimeW-1:0]     timer_q, timer_d;
  logic [CODE_BITS-1:0] shift_q, shift_d;
  logic [BitsW-1:0]     bits_q, bits_d;
  logic [CODE_BITS-1:0] code_ext;
  logic                 seg_end;
  logic                 tick;

  generate
    if (CODE_BITS > CodeW) begin : g_ext
      assign code_ext = {{(CODE_BITS - CodeW){1'b0}}, item_i.code_word};
    end else begin : g_trunc
      assign code_ext = item_i.code_word[CODE_BITS-1:0];
    end
  endgenerate

  assign tick    = step_i && !item_i.mode && (phase_q != PH_IDLE);
  assign seg_end = (timer_q == TimeW'(1));

  // next state
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    if (step_i && item_i.mode && (phase_q == PH_IDLE)) begin
      shift_d = code_ext;
      bits_d  = BitsW'(CODE_BITS);
      phase_d = PH_LEAD_HI;
      timer_d = seg_len(cfg_i.leader_high_time);
    end else if (tick) begin
      timer_d = timer_q - TimeW'(1);
      if (seg_end) begin
        case (phase_q)
          PH_LEAD_HI: begin
            phase_d = PH_LEAD_LO;
            timer_d = seg_len(cfg_i.leader_low_time);
          end
          PH_LEAD_LO: begin
            phase_d = PH_MARK;
            timer_d = seg_len(cfg_i.mark_time);
          end
          PH_MARK: begin
            phase_d = PH_SPACE;
            timer_d = shift_q[CODE_BITS-1] ? seg_len(cfg_i.one_space_time)
                                           : seg_len(cfg_i.zero_space_time);
          end
          default: begin
            shift_d = shift_q << 1;
            bits_d  = bits_q - BitsW'(1);
            if (bits_q == BitsW'(1)) begin
              phase_d = PH_IDLE;
              timer_d = '0;
            end else begin
              phase_d = PH_MARK;
              timer_d = seg_len(cfg_i.mark_time);
            end
          end
        endcase
      end
    end
  end

  // result of this item
  always_comb begin
    res_o.ir_level      = (phase_d inside {PH_LEAD_HI, PH_MARK});
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.frame_done    = tick && seg_end && (phase_q == PH_SPACE) &&
                          (bits_q == BitsW'(1));
    res_o.load_rejected = step_i && item_i.mode && (phase_q != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      shift_q <= '0;
      bits_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
    end
  end

endmodule

FILE: hw/rtl/ir_pulse_distance_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter - NEC style pulse-distance IR transmitter
// Leader then CODE_BITS bits, MSB first, paced by tick items; one result each.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Payload
//  in        in   in_valid_i/in_stall_o   in_data_i  (mode, code_word)
//  out       out  out_valid_o/out_stall_i out_data_o (ir_level .. load_rejected)
//  cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
//  One item per cycle unless stalled; result follows in the next cycle.
//  Throughput is set by the single result register; input stalls only while
//  that register holds an item that the output side is stalling.
//  Reset: timings return to 9000/4500/550/1700/550, block idle, no result.
//  Writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter #(
  parameter int unsigned CODE_BITS = irpdt_pkg::CodeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  irpdt_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output irpdt_pkg::out_item_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [irpdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irpdt_pkg::TimeW-1:0]    cfg_data_i
);
  import irpdt_pkg::*;

  cfg_t      cfg_q;
  out_item_t res_d, res_q;
  logic      out_valid_q;
  logic      accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_high_time <= LeaderHighRst;
      cfg_q.leader_low_time  <= LeaderLowRst;
      cfg_q.mark_time        <= MarkRst;
      cfg_q.one_space_time   <= OneSpaceRst;
      cfg_q.zero_space_time  <= ZeroSpaceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEADER_HIGH: cfg_q.leader_high_time <= cfg_data_i;
        CFG_LEADER_LOW:  cfg_q.leader_low_time  <= cfg_data_i;
        CFG_MARK:        cfg_q.mark_time        <= cfg_data_i;
        CFG_ONE_SPACE:   cfg_q.one_space_time   <= cfg_data_i;
        CFG_ZERO_SPACE:  cfg_q.zero_space_time  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  irpdt_seq #(
    .CODE_BITS(CODE_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

FILE: hw/rtl/irpdt_checker.sv
// ----------------------------------------------------------------------------
// irpdt_checker - port level checks for the IR transmitter
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module irpdt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input irpdt_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input irpdt_pkg::out_item_t out_data_o
);
  import irpdt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // every accepted item yields a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a load either starts the leader or is rejected
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode |=>
      out_data_o.load_rejected ||
      (out_data_o.busy_res && out_data_o.ir_level && !out_data_o.frame_done))
    else $error("load item neither started a frame nor was rejected");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_irpdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
